/* design/cdd_pkg.sv */
// shared types, constants and calendar functions for the day difference block
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

  localparam int unsigned MaxYearDef = 9999;
  localparam int unsigned YearCycle  = 400;
  localparam int unsigned DayW       = 5;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned YearW      = 14;
  localparam int unsigned CountW     = 22;
  localparam int unsigned ResW       = 9;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [DayW-1:0]   end_day;
    logic [MonthW-1:0] end_month;
    logic [YearW-1:0]  end_year;
    logic              include_end;
  } cdd_req_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic              bad_date;
  } cdd_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StRedStart,
    StRedEnd,
    StCheck,
    StWalk,
    StFinish
  } cdd_state_e;

  // sequencer commands to the datapath
  typedef struct packed {
    logic load;
    logic red_start;
    logic red_end;
    logic check;
    logic walk;
    logic finish;
  } cdd_ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic rem_lt;
    logic bad;
    logic earlier;
    logic at_end;
  } cdd_sts_t;

  // leap test on the year taken modulo 400
  function automatic logic is_leap(input logic [ResW-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* design/cdd_ctrl.sv */
// sequencer for the day difference block
`timescale 1ns / 1ps
`default_nettype none

module cdd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  input  wire cdd_pkg::cdd_sts_t sts_i,
  output cdd_pkg::cdd_ctl_t      ctl_o
);

  cdd_pkg::cdd_state_e state_q, state_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic                out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdd_pkg::StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdd_pkg::StIdle: begin
        if (req_valid_i) state_d = cdd_pkg::StRedStart;
      end
      cdd_pkg::StRedStart: begin
        if (sts_i.rem_lt) state_d = cdd_pkg::StRedEnd;
      end
      cdd_pkg::StRedEnd: begin
        if (sts_i.rem_lt) state_d = cdd_pkg::StCheck;
      end
      cdd_pkg::StCheck: begin
        if (sts_i.bad || !sts_i.earlier) state_d = cdd_pkg::StFinish;
        else state_d = cdd_pkg::StWalk;
      end
      cdd_pkg::StWalk: begin
        if (sts_i.at_end) state_d = cdd_pkg::StFinish;
      end
      cdd_pkg::StFinish: begin
        if (out_free) state_d = cdd_pkg::StIdle;
      end
      default: state_d = cdd_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      cdd_pkg::StIdle: begin
        req_ready_o = 1'b1;
        ctl_o.load  = req_valid_i;
      end
      cdd_pkg::StRedStart: ctl_o.red_start = 1'b1;
      cdd_pkg::StRedEnd:   ctl_o.red_end   = 1'b1;
      cdd_pkg::StCheck:    ctl_o.check     = 1'b1;
      cdd_pkg::StWalk:     ctl_o.walk      = !sts_i.at_end;
      cdd_pkg::StFinish:   ctl_o.finish    = out_free;
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (ctl_o.finish) rsp_valid_d = 1'b1;
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

/* design/cdd_dp.sv */
// datapath: year reduction, date checks, day walk and response register
`timescale 1ns / 1ps
`default_nettype none

module cdd_dp #(
  parameter int unsigned MAX_YEAR = cdd_pkg::MaxYearDef
) (
  input  wire logic              clk_i,
  input  wire cdd_pkg::cdd_req_t req_i,
  input  wire cdd_pkg::cdd_ctl_t ctl_i,
  output cdd_pkg::cdd_sts_t      sts_o,
  output cdd_pkg::cdd_rsp_t      rsp_o
);

  localparam logic [16:0] MaxYear = 17'(MAX_YEAR);
  localparam logic [cdd_pkg::YearW-1:0] Cycle = cdd_pkg::YearW'(cdd_pkg::YearCycle);
  localparam logic [cdd_pkg::ResW-1:0] ResLast = cdd_pkg::ResW'(cdd_pkg::YearCycle - 1);

  cdd_pkg::cdd_req_t             req_q;
  cdd_pkg::cdd_rsp_t             rsp_q;
  logic [cdd_pkg::YearW-1:0]     rem_q;
  logic [cdd_pkg::ResW-1:0]      sres_q, eres_q;
  logic [cdd_pkg::DayW-1:0]      wday_q;
  logic [cdd_pkg::MonthW-1:0]    wmon_q;
  logic [cdd_pkg::YearW-1:0]     wyear_q;
  logic [cdd_pkg::CountW-1:0]    cnt_q;
  logic                          bad_q;

  logic                          rem_lt;
  logic [cdd_pkg::YearW-1:0]     rem_sub;
  logic [cdd_pkg::DayW-1:0]      s_len, e_len, w_len;
  logic                          s_ok, e_ok;
  logic                          earlier, at_end;
  logic [cdd_pkg::CountW:0]      fin_sum;
  logic [cdd_pkg::CountW-1:0]    fin_cnt;

  // shared compare-subtract unit for the year reduction
  assign rem_lt  = rem_q < Cycle;
  assign rem_sub = rem_q - Cycle;

  assign s_len = cdd_pkg::month_len(req_q.start_month, cdd_pkg::is_leap(sres_q));
  assign e_len = cdd_pkg::month_len(req_q.end_month, cdd_pkg::is_leap(eres_q));
  assign w_len = cdd_pkg::month_len(wmon_q, cdd_pkg::is_leap(sres_q));

  assign s_ok = (req_q.start_month >= cdd_pkg::MonthJan) && (req_q.start_month <= cdd_pkg::MonthDec)
             && (req_q.start_day != '0) && (req_q.start_day <= s_len)
             && ({3'b000, req_q.start_year} <= MaxYear);
  assign e_ok = (req_q.end_month >= cdd_pkg::MonthJan) && (req_q.end_month <= cdd_pkg::MonthDec)
             && (req_q.end_day != '0) && (req_q.end_day <= e_len)
             && ({3'b000, req_q.end_year} <= MaxYear);

  assign earlier = {req_q.start_year, req_q.start_month, req_q.start_day}
                 < {req_q.end_year, req_q.end_month, req_q.end_day};
  assign at_end = {wyear_q, wmon_q, wday_q} == {req_q.end_year, req_q.end_month, req_q.end_day};

  assign fin_sum = {1'b0, cnt_q} + {{cdd_pkg::CountW{1'b0}}, req_q.include_end};
  assign fin_cnt = fin_sum[cdd_pkg::CountW] ? cdd_pkg::CountMax : fin_sum[cdd_pkg::CountW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
      rem_q <= req_i.start_year;
    end
    if (ctl_i.red_start) begin
      if (rem_lt) begin
        sres_q <= rem_q[cdd_pkg::ResW-1:0];
        rem_q  <= req_q.end_year;
      end else begin
        rem_q <= rem_sub;
      end
    end
    if (ctl_i.red_end) begin
      if (rem_lt) eres_q <= rem_q[cdd_pkg::ResW-1:0];
      else rem_q <= rem_sub;
    end
    if (ctl_i.check) begin
      bad_q   <= !(s_ok && e_ok);
      wday_q  <= req_q.start_day;
      wmon_q  <= req_q.start_month;
      wyear_q <= req_q.start_year;
      cnt_q   <= '0;
    end
    if (ctl_i.walk) begin
      if (cnt_q != cdd_pkg::CountMax) cnt_q <= cnt_q + 1'b1;
      if (wday_q == w_len) begin
        wday_q <= 5'd1;
        if (wmon_q == cdd_pkg::MonthDec) begin
          wmon_q  <= cdd_pkg::MonthJan;
          wyear_q <= wyear_q + 1'b1;
          sres_q  <= (sres_q == ResLast) ? '0 : sres_q + 1'b1;
        end else begin
          wmon_q <= wmon_q + 1'b1;
        end
      end else begin
        wday_q <= wday_q + 1'b1;
      end
    end
    if (ctl_i.finish) begin
      rsp_q.day_count <= bad_q ? '0 : fin_cnt;
      rsp_q.bad_date  <= bad_q;
    end
  end

  always_comb begin
    sts_o.rem_lt  = rem_lt;
    sts_o.bad     = !(s_ok && e_ok);
    sts_o.earlier = earlier;
    sts_o.at_end  = at_end;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

/* design/calendar_day_difference.sv */
// top level of the gregorian day difference block
//
// channel  dir  handshake                  payload
// req      in   req_valid_i / req_ready_o  req_i (cdd_req_t)
// rsp      out  rsp_valid_o / rsp_ready_i  rsp_o (cdd_rsp_t)
//
// after a request is taken the start year is reduced, then the end year, then both dates are checked
// and the walk counts the day distance; a bad date or a start not before the end skips the walk
// the walk advances one day per cycle; the finish step registers the response and its valid
// the year reduction uses one shared compare-subtract unit, 400 years a cycle
// reset clears the sequencer and response valid only
// the response waits in its own register while a new request is taken; the next finish waits
`timescale 1ns / 1ps
`default_nettype none

module calendar_day_difference #(
  parameter int unsigned MAX_YEAR = cdd_pkg::MaxYearDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire cdd_pkg::cdd_req_t req_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output cdd_pkg::cdd_rsp_t      rsp_o
);

  cdd_pkg::cdd_ctl_t ctl;
  cdd_pkg::cdd_sts_t sts;

  cdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  cdd_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i (clk_i),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule

`default_nettype wire

/* design/cdd_checker.sv */
// port-level checks for the day difference block
`timescale 1ns / 1ps
`default_nettype none

module cdd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_o,
  input wire logic              rsp_valid_o,
  input wire logic              rsp_ready_i,
  input wire cdd_pkg::cdd_rsp_t rsp_o
);

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // bad date gives zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.bad_date |-> rsp_o.day_count == '0)
    else $error("bad date with nonzero count");

  // busy after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while busy");

  // no response appears right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !$rose(rsp_valid_o))
    else $error("response too early");

endmodule

bind calendar_day_difference cdd_checker u_cdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire
